### src/hds_pkg.sv
package hds_pkg;

    // field and register widths
    localparam int DATA_W = 32;
    localparam int COEF_W = 16;
    localparam int ROWS_W = 11;
    localparam int COLS_W = 6;

    // grid limits
    localparam int MAX_COLS = 32;
    localparam int MAX_ROWS = 1024;
    localparam int MIN_DIM  = 3;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);

    // arithmetic widths
    localparam int FRAC_W  = 16;
    localparam int DIFF_W  = DATA_W + 3;
    localparam int PROD_W  = DIFF_W + COEF_W + 1;
    localparam int DELTA_W = PROD_W + 2;
    localparam int Q_W     = DELTA_W - FRAC_W;
    localparam int RES_W   = Q_W + 1;
    localparam logic signed [DELTA_W-1:0] ROUND_HALF = DELTA_W'(1) <<< (FRAC_W - 1);
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_COL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd3;
    localparam int CFG_DATA_W = COEF_W;

    // register reset values
    localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(66);
    localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(11);
    localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(11);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one classified item
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [COL_W-1:0]  col;
        logic              emit;
        logic              interior;
        logic              frame_end;
    } t_item;

endpackage

### src/heat_diffusion_stencil_step_top.sv
// Five-point heat stencil, one explicit Euler step per frame in raster order.
// Grid values enter one per item on the slave stream and the block takes one
// item per clock while its four-entry queue has room; a result for a point
// follows the item of the point below it through the memory, difference,
// product and sum stages to the output register. The last item of a frame
// is followed by the whole last row, read back from the line buffer at one
// value per cycle while the output is not stalled, and no item leaves the
// queue meanwhile. The line buffer is a single RAM of 32 words holding the
// two rows above the current one, with one write port and two read ports.
// Border points pass unchanged; interior points saturate to the signed Q15.16
// range. The user must write coefficients and grid size through the config
// port only while the block is idle; the block itself does not enforce it.
// Sizes outside range are clamped to 3..1024 rows and 3..32 columns.
module heat_diffusion_stencil_step_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [hds_pkg::DATA_W-1:0]     s_axis_tdata,   // [31:0] cell_value
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [hds_pkg::DATA_W-1:0]     m_axis_tdata,   // [31:0] next_value
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_we,
    input  logic [hds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hds_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [hds_pkg::COEF_W-1:0] r_coef_row;
    logic [hds_pkg::COEF_W-1:0] r_coef_col;
    logic [hds_pkg::ROWS_W-1:0] r_grid_rows;
    logic [hds_pkg::COLS_W-1:0] r_grid_cols;
    logic [hds_pkg::ROWS_W-1:0] eff_rows;
    logic [hds_pkg::COLS_W-1:0] eff_cols;

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    hds_pkg::t_item push_item;
    hds_pkg::t_item head_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_row  <= hds_pkg::COEF_RESET;
            r_coef_col  <= hds_pkg::COEF_RESET;
            r_grid_rows <= hds_pkg::ROWS_RESET;
            r_grid_cols <= hds_pkg::COLS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hds_pkg::CFG_COEF_ROW:  r_coef_row  <= i_cfg_data;
                hds_pkg::CFG_COEF_COL:  r_coef_col  <= i_cfg_data;
                hds_pkg::CFG_GRID_ROWS: r_grid_rows <= i_cfg_data[hds_pkg::ROWS_W-1:0];
                hds_pkg::CFG_GRID_COLS: r_grid_cols <= i_cfg_data[hds_pkg::COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp grid size to the supported range
    always_comb begin
        eff_rows = r_grid_rows;
        if (r_grid_rows < hds_pkg::ROWS_W'(hds_pkg::MIN_DIM)) begin
            eff_rows = hds_pkg::ROWS_W'(hds_pkg::MIN_DIM);
        end else if (r_grid_rows > hds_pkg::ROWS_W'(hds_pkg::MAX_ROWS)) begin
            eff_rows = hds_pkg::ROWS_W'(hds_pkg::MAX_ROWS);
        end
        eff_cols = r_grid_cols;
        if (r_grid_cols < hds_pkg::COLS_W'(hds_pkg::MIN_DIM)) begin
            eff_cols = hds_pkg::COLS_W'(hds_pkg::MIN_DIM);
        end else if (r_grid_cols > hds_pkg::COLS_W'(hds_pkg::MAX_COLS)) begin
            eff_cols = hds_pkg::COLS_W'(hds_pkg::MAX_COLS);
        end
    end

    hds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_rows  (eff_rows),
        .i_cols  (eff_cols),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_item  (push_item)
    );

    hds_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    hds_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (head_item),
        .o_q_pop    (q_pop),
        .i_coef_row (r_coef_row),
        .i_coef_col (r_coef_col),
        .i_cols     (eff_cols),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_value    (m_axis_tdata),
        .o_last     (m_axis_tlast)
    );

endmodule

### src/hds_ram.sv
module hds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

### src/hds_front.sv
module hds_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hds_pkg::DATA_W-1:0]  i_data,
    input  logic [hds_pkg::ROWS_W-1:0]  i_rows,
    input  logic [hds_pkg::COLS_W-1:0]  i_cols,
    input  logic                        i_full,
    output logic                        o_push,
    output hds_pkg::t_item              o_item
);

    logic [hds_pkg::ROW_W-1:0]  r_row;
    logic [hds_pkg::COL_W-1:0]  r_col;
    logic [hds_pkg::ROW_W-1:0]  n_row;
    logic [hds_pkg::COL_W-1:0]  n_col;
    logic [hds_pkg::ROWS_W-1:0] row_next;
    logic [hds_pkg::COLS_W-1:0] col_next;
    logic                       row_end;
    logic                       frame_end;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // classify the item by its grid position
    always_comb begin
        row_next  = hds_pkg::ROWS_W'(r_row) + hds_pkg::ROWS_W'(1);
        col_next  = hds_pkg::COLS_W'(r_col) + hds_pkg::COLS_W'(1);
        row_end   = col_next >= i_cols;
        frame_end = row_end && (row_next >= i_rows);

        o_item.value     = i_data;
        o_item.col       = r_col;
        o_item.emit      = r_row != '0;
        o_item.interior  = (r_row >= hds_pkg::ROW_W'(2)) && (row_next <= i_rows)
                           && (r_col != '0) && (col_next < i_cols);
        o_item.frame_end = frame_end;

        n_row = r_row;
        n_col = r_col;
        if (o_push) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : hds_pkg::ROW_W'(row_next);
            end else begin
                n_col = hds_pkg::COL_W'(col_next);
            end
        end
    end

    // raster position of the next item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

### src/hds_fifo.sv
module hds_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hds_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output hds_pkg::t_item o_item
);

    hds_pkg::t_item              r_mem [hds_pkg::QUEUE_DEPTH];
    logic [hds_pkg::QPTR_W-1:0]  r_wptr;
    logic [hds_pkg::QPTR_W-1:0]  r_rptr;
    logic [hds_pkg::QCNT_W-1:0]  r_count;

    assign o_full  = r_count == hds_pkg::QCNT_W'(hds_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + hds_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + hds_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + hds_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - hds_pkg::QCNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

### src/hds_back.sv
module hds_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  hds_pkg::t_item              i_q_item,
    output logic                        o_q_pop,
    input  logic [hds_pkg::COEF_W-1:0]  i_coef_row,
    input  logic [hds_pkg::COEF_W-1:0]  i_coef_col,
    input  logic [hds_pkg::COLS_W-1:0]  i_cols,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hds_pkg::DATA_W-1:0]  o_value,
    output logic                        o_last
);

    localparam int DW = hds_pkg::DATA_W;

    logic                       adv;
    logic                       flush_last;
    logic                       ram_we;
    logic [2*DW-1:0]            ram_wdata;
    logic [hds_pkg::COL_W-1:0]  raddr_a;
    logic [hds_pkg::COL_W-1:0]  raddr_b;
    logic [2*DW-1:0]            rdata_a;
    logic [2*DW-1:0]            rdata_b;

    // flush sequencer
    logic                       r_flush;
    logic [hds_pkg::COL_W-1:0]  r_flush_idx;

    // memory stage
    logic                       r_m_valid;
    logic                       r_m_flush;
    logic                       r_m_last;
    hds_pkg::t_item             r_m_item;
    logic [DW-1:0]              r_prev_center;

    // difference stage
    logic                              r_c_valid;
    logic                              r_c_int;
    logic                              r_c_last;
    logic [DW-1:0]                     r_c_p;
    logic signed [hds_pkg::DIFF_W-1:0] r_c_drow;
    logic signed [hds_pkg::DIFF_W-1:0] r_c_dcol;

    // product stage
    logic                              r_d_valid;
    logic                              r_d_int;
    logic                              r_d_last;
    logic [DW-1:0]                     r_d_p;
    logic signed [hds_pkg::PROD_W-1:0] r_d_prod_row;
    logic signed [hds_pkg::PROD_W-1:0] r_d_prod_col;

    // sum stage
    logic                               r_e_valid;
    logic                               r_e_int;
    logic                               r_e_last;
    logic [DW-1:0]                      r_e_p;
    logic signed [hds_pkg::DELTA_W-1:0] r_e_delta;

    // output register
    logic          r_out_valid;
    logic [DW-1:0] r_out_value;
    logic          r_out_last;

    logic [DW-1:0]                      center;
    logic [DW-1:0]                      up;
    logic [DW-1:0]                      right;
    logic signed [hds_pkg::DIFF_W-1:0]  drow;
    logic signed [hds_pkg::DIFF_W-1:0]  dcol;
    logic signed [hds_pkg::DIFF_W-1:0]  two_p;
    logic signed [hds_pkg::PROD_W-1:0]  prod_row;
    logic signed [hds_pkg::PROD_W-1:0]  prod_col;
    logic signed [hds_pkg::DELTA_W-1:0] delta;
    logic signed [hds_pkg::Q_W-1:0]     q;
    logic signed [hds_pkg::RES_W-1:0]   res;
    logic [hds_pkg::RES_W-DW:0]         res_top;
    logic [DW-1:0]                      sat_value;
    logic [DW-1:0]                      result;

    // whole back end moves when the output register can take a result
    assign adv        = !r_out_valid || i_ready;
    assign o_q_pop    = adv && !r_flush && i_q_valid;
    assign flush_last = (hds_pkg::COLS_W'(r_flush_idx) + hds_pkg::COLS_W'(1)) == i_cols;

    // line buffer read and write addresses
    assign raddr_a   = r_flush ? r_flush_idx : i_q_item.col;
    assign raddr_b   = i_q_item.col + hds_pkg::COL_W'(1);
    assign ram_we    = adv && r_m_valid && !r_m_flush;
    assign ram_wdata = {center, r_m_item.value};

    // upper half holds the older row, lower half the middle row
    hds_ram #(
        .WIDTH (2 * hds_pkg::DATA_W),
        .DEPTH (hds_pkg::MAX_COLS)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_m_item.col),
        .i_wdata   (ram_wdata),
        .i_rd_en   (adv),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // stencil neighbours and second differences
    always_comb begin
        center = rdata_a[DW-1:0];
        up     = rdata_a[2*DW-1:DW];
        right  = rdata_b[DW-1:0];
        two_p  = hds_pkg::DIFF_W'($signed(center)) <<< 1;
        drow   = hds_pkg::DIFF_W'($signed(up)) + hds_pkg::DIFF_W'($signed(r_m_item.value))
                 - two_p;
        dcol   = hds_pkg::DIFF_W'($signed(r_prev_center)) + hds_pkg::DIFF_W'($signed(right))
                 - two_p;
    end

    // weighted differences, rounding and saturation
    always_comb begin
        prod_row = $signed({1'b0, i_coef_row}) * r_c_drow;
        prod_col = $signed({1'b0, i_coef_col}) * r_c_dcol;
        delta    = hds_pkg::DELTA_W'(r_d_prod_row) + hds_pkg::DELTA_W'(r_d_prod_col)
                   + hds_pkg::ROUND_HALF;
        q        = $signed(r_e_delta[hds_pkg::DELTA_W-1:hds_pkg::FRAC_W]);
        res      = hds_pkg::RES_W'($signed(r_e_p)) + hds_pkg::RES_W'(q);
        res_top  = res[hds_pkg::RES_W-1:DW-1];
        if ((&res_top) || !(|res_top)) begin
            sat_value = res[DW-1:0];
        end else begin
            sat_value = res[hds_pkg::RES_W-1] ? hds_pkg::SAT_MIN : hds_pkg::SAT_MAX;
        end
        result = r_e_int ? sat_value : r_e_p;
    end

    // control state of every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush     <= 1'b0;
            r_flush_idx <= '0;
            r_m_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_e_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            if (r_flush) begin
                r_flush_idx <= r_flush_idx + hds_pkg::COL_W'(1);
                if (flush_last) begin
                    r_flush <= 1'b0;
                end
            end else if (i_q_valid && i_q_item.frame_end) begin
                r_flush     <= 1'b1;
                r_flush_idx <= '0;
            end
            r_m_valid   <= r_flush || i_q_valid;
            r_c_valid   <= r_m_valid && (r_m_flush || r_m_item.emit);
            r_d_valid   <= r_c_valid;
            r_e_valid   <= r_d_valid;
            r_out_valid <= r_e_valid;
        end
    end

    // payload of every stage
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_flush <= r_flush;
            r_m_last  <= r_flush && flush_last;
            r_m_item  <= i_q_item;
            if (r_m_valid && !r_m_flush) begin
                r_prev_center <= center;
            end

            r_c_int  <= !r_m_flush && r_m_item.interior;
            r_c_last <= r_m_flush && r_m_last;
            r_c_p    <= center;
            r_c_drow <= drow;
            r_c_dcol <= dcol;

            r_d_int      <= r_c_int;
            r_d_last     <= r_c_last;
            r_d_p        <= r_c_p;
            r_d_prod_row <= prod_row;
            r_d_prod_col <= prod_col;

            r_e_int   <= r_d_int;
            r_e_last  <= r_d_last;
            r_e_p     <= r_d_p;
            r_e_delta <= delta;

            r_out_value <= result;
            r_out_last  <= r_e_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_last  = r_out_last;

endmodule
